[rtl/wsir_pkg.sv]
// shared types and constants for the window stack input router
`timescale 1ns / 1ps
package wsir_pkg;
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [12:0] SIZE_MAX = 13'd4096;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_DESTROY = 3'd1,
        CMD_MOVE_X  = 3'd2,
        CMD_MOVE_Y  = 3'd3,
        CMD_BUTTON  = 3'd4,
        CMD_KEY     = 3'd5,
        CMD_RSVD6   = 3'd6,
        CMD_RSVD7   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        EV_CREATED = 2'd0,
        EV_POINTER = 2'd1,
        EV_KEY     = 2'd2
    } t_event;

    localparam logic [15:0] BTN_LEFT   = 16'h0110;
    localparam logic [15:0] BTN_RIGHT  = 16'h0111;
    localparam logic [15:0] BTN_MIDDLE = 16'h0112;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CREATE_WR,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_OWN_WAIT,
        ST_EMIT,
        ST_OUT
    } t_state;

    // slot number modulo six, as a constant lookup
    function automatic logic [2:0] slot_mod6(input logic [SLOT_W-1:0] s);
        logic [2:0] m;
        m = '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (s == SLOT_W'(k)) m = 3'(k % 6);
        end
        return m;
    endfunction

    // window origin, worked out from slot number
    function automatic logic [13:0] origin_x(input logic [SLOT_W-1:0] s);
        logic [2:0] m;
        m = slot_mod6(s);
        return 14'd80 + 14'(m) * 14'd48;
    endfunction

    function automatic logic [13:0] origin_y(input logic [SLOT_W-1:0] s);
        logic [2:0] m;
        m = slot_mod6(s);
        return 14'd88 + 14'(m) * 14'd40;
    endfunction
endpackage

[rtl/window_stack_input_router.sv]
// top level of the window stack input router
`timescale 1ns / 1ps
// Window stack input router.
// Input channel: one command beat (create, destroy, motion, button, key) per
// i_valid/o_ready handshake. Output channel: at most one event beat per
// command, presented on o_valid and held until i_ready.
// Configuration channel: i_cfg_valid/o_cfg_ready with index and data;
// writing either screen size re-centres the cursor. Write only while idle.
// Each command is handled alone by a sequencer around three slot memories
// (window number, owner, stacking order), each with one registered read port.
// Path to o_valid: a create finds a free slot in the scan state, then does the
// table and stack writes; pointer and key beats read the stack top, then the
// owner, then emit. Reserved commands leave the input ready; a destroy holds
// the input through a number scan of every slot, then a compaction pass that
// reads each stack entry and writes back all but the destroyed slot.
// The result sits in an output register; the next command is accepted while
// it waits, and the sequencer stalls only when a second result is ready.
// Reset: empty stack, no slots used, window numbers from 1, screen 1024x768
// with cursor centred, buttons released. No clearing pass is needed.
module window_stack_input_router (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_command,
    input  logic [15:0]           i_client_id,
    input  logic [15:0]           i_window_id,
    input  logic [15:0]           i_code,
    input  logic signed [15:0]    i_amount,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_event_kind,
    output logic [15:0]           o_dest_client,
    output logic [15:0]           o_event_window,
    output logic signed [13:0]    o_pointer_x,
    output logic signed [13:0]    o_pointer_y,
    output logic [2:0]            o_button_bits,
    output logic [15:0]           o_key_value,
    output logic                  o_key_down,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [12:0]           i_cfg_data
);
    import wsir_pkg::*;

    logic [15:0]       mem_win [SLOT_COUNT];
    logic [15:0]       mem_own [SLOT_COUNT];
    logic [SLOT_W-1:0] mem_stk [SLOT_COUNT];

    t_state r_state, n_state;
    logic [SLOT_COUNT-1:0] r_used, n_used;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [15:0]       r_next_win, n_next_win;
    logic [12:0]       r_width, r_height;
    logic [11:0]       r_cur_x, r_cur_y;
    logic [2:0]        r_buttons;

    // latched command
    t_cmd              r_cmd;
    logic [15:0]       r_client, r_winid, r_code;
    logic signed [15:0] r_amount;

    logic [CNT_W-1:0]  r_idx, n_idx;   // scan / read index
    logic [CNT_W-1:0]  r_wptr, n_wptr; // compaction write pointer
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_found, n_found;

    // memory ports
    logic              win_we, own_we, stk_we;
    logic [SLOT_W-1:0] win_wa, stk_wa, win_ra, own_ra, stk_ra;
    logic [15:0]       win_wd;
    logic [SLOT_W-1:0] stk_wd;
    logic [15:0]       win_rd, own_rd;
    logic [SLOT_W-1:0] stk_rd;
    logic              r_scan_v;       // win_rd belongs to a scan read
    logic [SLOT_W-1:0] r_scan_slot;

    // output register
    logic              r_ovalid;
    t_event            r_kind;
    logic [15:0]       r_dest, r_ewin, r_key;
    logic [13:0]       r_px, r_py;
    logic [2:0]        r_obits;
    logic              r_kdown;
    logic              emit;

    always_ff @(posedge i_clk) begin
        if (win_we) mem_win[win_wa] <= win_wd;
        if (own_we) mem_own[win_wa] <= r_client;
        if (stk_we) mem_stk[stk_wa] <= stk_wd;
        win_rd <= mem_win[win_ra];
        own_rd <= mem_own[own_ra];
        stk_rd <= mem_stk[stk_ra];
    end

    logic accept;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign accept      = i_valid && o_ready;

    // size clamp for register writes
    logic [12:0] cfg_sz;
    always_comb begin
        if (i_cfg_data == 13'd0)        cfg_sz = 13'd1;
        else if (i_cfg_data > SIZE_MAX) cfg_sz = SIZE_MAX;
        else                            cfg_sz = i_cfg_data;
    end

    // cursor update, clamped per item
    logic signed [17:0] mv_x, mv_y;
    logic [11:0] n_cur_x, n_cur_y;
    logic [2:0]  btn_bit;
    always_comb begin
        mv_x = 18'(signed'({1'b0, r_cur_x}));
        mv_y = 18'(signed'({1'b0, r_cur_y}));
        if (r_cmd == CMD_MOVE_X) mv_x = mv_x + 18'(r_amount);
        if (r_cmd == CMD_MOVE_Y) mv_y = mv_y + 18'(r_amount);
        if (mv_x < 0) n_cur_x = '0;
        else if (mv_x >= 18'(r_width)) n_cur_x = 12'(r_width - 13'd1);
        else n_cur_x = mv_x[11:0];
        if (mv_y < 0) n_cur_y = '0;
        else if (mv_y >= 18'(r_height)) n_cur_y = 12'(r_height - 13'd1);
        else n_cur_y = mv_y[11:0];
        priority case (r_code)
            BTN_LEFT:   btn_bit = 3'b001;
            BTN_RIGHT:  btn_bit = 3'b010;
            BTN_MIDDLE: btn_bit = 3'b100;
            default:    btn_bit = 3'b000;
        endcase
    end

    logic [SLOT_W-1:0] free_slot;
    logic              free_any;
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_slot = SLOT_W'(k);
                free_any  = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_used = r_used;
        n_count = r_count;
        n_next_win = r_next_win;
        n_idx = r_idx;
        n_wptr = r_wptr;
        n_slot = r_slot;
        n_found = r_found;
        win_we = 1'b0;
        own_we = 1'b0;
        stk_we = 1'b0;
        win_wa = r_slot;
        win_wd = r_next_win;
        stk_wa = r_wptr[SLOT_W-1:0];
        stk_wd = stk_rd;
        win_ra = r_idx[SLOT_W-1:0];
        own_ra = r_slot;
        stk_ra = r_idx[SLOT_W-1:0];
        emit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_found = 1'b0;
                    unique case (t_cmd'(i_command))
                        CMD_CREATE:  n_state = ST_SCAN;
                        CMD_DESTROY: n_state = ST_SCAN;
                        CMD_MOVE_X, CMD_MOVE_Y, CMD_BUTTON, CMD_KEY:
                            n_state = ST_TOP_RD;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_cmd == CMD_CREATE) begin
                    if (!free_any) n_state = ST_IDLE;
                    else begin
                        n_slot = free_slot;
                        n_state = ST_CREATE_WR;
                    end
                end else begin
                    // read one number a cycle, compare the one read last cycle
                    if (r_scan_v && !r_found && r_used[r_scan_slot]
                            && win_rd == r_winid) begin
                        n_found = 1'b1;
                        n_slot = r_scan_slot;
                    end
                    if (r_idx != CNT_W'(SLOT_COUNT)) n_idx = r_idx + 1'b1;
                    else if (!r_scan_v) begin
                        if (n_found) begin
                            n_idx = '0;
                            n_wptr = '0;
                            n_state = ST_DROP_RD;
                        end else n_state = ST_IDLE;
                    end
                end
            end
            ST_CREATE_WR: begin
                // hold while an earlier beat still waits in the output register
                if (!r_ovalid || i_ready) begin
                    win_we = 1'b1;
                    own_we = 1'b1;
                    n_used[r_slot] = 1'b1;
                    n_next_win = r_next_win + 16'd1;
                    n_idx = '0;
                    n_wptr = '0;
                    // a free slot is never on the stack, append at the front
                    stk_we = 1'b1;
                    stk_wa = r_count[SLOT_W-1:0];
                    stk_wd = r_slot;
                    n_count = r_count + 1'b1;
                    emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DROP_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_wptr;
                    n_used[r_slot] = 1'b0;
                    n_state = ST_IDLE;
                end else n_state = ST_DROP_WR;
            end
            ST_DROP_WR: begin
                if (stk_rd != r_slot) begin
                    stk_we = 1'b1;
                    n_wptr = r_wptr + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                stk_ra = n_idx[SLOT_W-1:0];
                n_state = ST_DROP_RD;
            end
            ST_TOP_RD: begin
                if (r_cmd == CMD_BUTTON && btn_bit == 3'b000) n_state = ST_IDLE;
                else if (r_count == '0) n_state = ST_IDLE;
                else begin
                    stk_ra = SLOT_W'(r_count - 1'b1);
                    n_state = ST_TOP_WAIT;
                end
            end
            ST_TOP_WAIT: begin
                n_slot = stk_rd;
                own_ra = stk_rd;
                n_state = ST_OWN_WAIT;
            end
            ST_OWN_WAIT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used <= '0;
            r_count <= '0;
            r_next_win <= 16'd1;
            r_width <= 13'd1024;
            r_height <= 13'd768;
            r_cur_x <= 12'd512;
            r_cur_y <= 12'd384;
            r_buttons <= '0;
            r_ovalid <= 1'b0;
            r_scan_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_count <= n_count;
            r_next_win <= n_next_win;
            r_scan_v <= (r_state == ST_SCAN) && (r_idx != CNT_W'(SLOT_COUNT));
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_WIDTH) begin
                    r_width <= cfg_sz;
                    r_cur_x <= cfg_sz[12:1];
                    r_cur_y <= r_height[12:1];
                end else begin
                    r_height <= cfg_sz;
                    r_cur_y <= cfg_sz[12:1];
                    r_cur_x <= r_width[12:1];
                end
            end
            if (r_state == ST_TOP_RD && r_cmd != CMD_KEY
                    && !(r_cmd == CMD_BUTTON && btn_bit == 3'b000)) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                if (r_cmd == CMD_BUTTON) begin
                    if (r_amount != 0) r_buttons <= r_buttons | btn_bit;
                    else r_buttons <= r_buttons & ~btn_bit;
                end
            end
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_wptr <= n_wptr;
        r_slot <= n_slot;
        r_found <= n_found;
        r_scan_slot <= r_idx[SLOT_W-1:0];
        if (accept) begin
            r_cmd <= t_cmd'(i_command);
            r_client <= i_client_id;
            r_winid <= i_window_id;
            r_code <= i_code;
            r_amount <= i_amount;
        end
        if (emit) begin
            r_ewin <= '0; r_px <= '0; r_py <= '0; r_obits <= '0;
            r_key <= '0; r_kdown <= 1'b0;
            if (r_state == ST_CREATE_WR) begin
                r_kind <= EV_CREATED;
                r_dest <= r_client;
                r_ewin <= r_next_win;
            end else if (r_cmd == CMD_KEY) begin
                r_kind <= EV_KEY;
                r_dest <= own_rd;
                r_key <= r_code;
                r_kdown <= (r_amount != 0);
            end else begin
                r_kind <= EV_POINTER;
                r_dest <= own_rd;
                r_px <= {2'b00, r_cur_x} - origin_x(r_slot);
                r_py <= {2'b00, r_cur_y} - origin_y(r_slot);
                r_obits <= r_buttons;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_event_kind = r_kind;
    assign o_dest_client = r_dest;
    assign o_event_window = r_ewin;
    assign o_pointer_x = r_px;
    assign o_pointer_y = r_py;
    assign o_button_bits = r_obits;
    assign o_key_value = r_key;
    assign o_key_down = r_kdown;
endmodule

[rtl/wsir_checker.sv]
// port-level checks for the window stack input router
`timescale 1ns / 1ps
module wsir_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_command,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_event_kind,
    input logic [15:0] o_dest_client,
    input logic [15:0] o_event_window,
    input logic [15:0] o_key_value,
    input logic        o_cfg_ready
);
    import wsir_pkg::*;

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_kind != 2'd3)) else $error("bad event kind");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dest_client)
        && $stable(o_event_window)) else $error("result beat changed");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == o_cfg_ready) else $error("cfg ready mismatch");
    // reserved commands leave the input ready, all others occupy the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && t_cmd'(i_command) != CMD_RSVD6
        && t_cmd'(i_command) != CMD_RSVD7 |=> !o_ready)
        else $error("accepted while busy");
    a_keyzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == EV_CREATED |-> o_key_value == 16'd0)
        else $error("key field set on created beat");
endmodule

bind window_stack_input_router wsir_checker u_wsir_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_command(i_command),
    .o_valid(o_valid), .i_ready(i_ready), .o_event_kind(o_event_kind),
    .o_dest_client(o_dest_client), .o_event_window(o_event_window),
    .o_key_value(o_key_value), .o_cfg_ready(o_cfg_ready)
);
